>>> hw/rtl/linear_blend_vertex_skinning_top_defines.svh
// Assertion macros for the skinning block.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_TOP_DEFINES_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lbvs_pkg.sv
// Shared types, constants and helpers of the skinning block.
package lbvs_pkg;

  localparam logic [2:0] MODE_WRITE = 3'd0;
  localparam int WORDS_PER_BONE = 12;
  localparam int RECIP_12 = 2731;  // floor(slot*2731/2^15) == slot/12 for slot < 3072
  localparam int WT_W = 19;
  localparam logic signed [WT_W-1:0] ONE_Q15 = 19'sd32768;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic                   first;
    logic                   last;
    logic signed [WT_W-1:0] wt;
    logic [63:0]            texcoord;
    logic                   batch;
  } beat_ctl_t;

  function automatic word_t sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

>>> hw/rtl/linear_blend_vertex_skinning_top.sv
// Top level of the four-influence linear blend skinning pipeline.
//
// Input channel in_valid/in_ready carries one item per transfer. Mode 0
// writes one 32-bit palette word (pos_x) at matrix_slot. Modes 1..4 skin
// a vertex: one bone matrix (twelve words, one word from each of twelve
// column RAMs) is read per cycle while the output is not stalled, one per
// influence; a new item is taken as the last influence of a vertex
// issues. The single read port of the palette sets this pace.
// Output channel out_valid/out_ready: one transfer per skinned vertex, in
// order. A vertex passes the transform registers s1, s2 and out, then the
// blend registers b1, fin and out, before out_valid rises. Palette writes
// and ignored modes give no output transfer.
// When the receiver stalls, every stage holds its contents and in_ready
// drops; nothing is lost or repeated.
// Reset clears all valid flags and the sequencer; the palette is not
// cleared, and words must be written before a vertex uses them.
module linear_blend_vertex_skinning_top #(
  parameter int MAX_BONES = 256,
  parameter int MAX_INFLUENCES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          mode,
  input  lbvs_pkg::word_t     pos_x,
  input  lbvs_pkg::word_t     pos_y,
  input  lbvs_pkg::word_t     pos_z,
  input  lbvs_pkg::word_t     nrm_x,
  input  lbvs_pkg::word_t     nrm_y,
  input  lbvs_pkg::word_t     nrm_z,
  input  logic [63:0]         texcoord,
  input  logic [31:0]         bone_indices,
  input  logic [47:0]         weights,
  input  logic [11:0]         matrix_slot,
  input  logic                last_vertex,
  output logic                out_valid,
  input  logic                out_ready,
  output lbvs_pkg::word_t     skinned_pos_x,
  output lbvs_pkg::word_t     skinned_pos_y,
  output lbvs_pkg::word_t     skinned_pos_z,
  output lbvs_pkg::word_t     skinned_nrm_x,
  output lbvs_pkg::word_t     skinned_nrm_y,
  output lbvs_pkg::word_t     skinned_nrm_z,
  output logic [63:0]         texcoord_out,
  output logic                batch_end
);
  import lbvs_pkg::*;

  // only 256 bones are reachable through 8-bit indices and 12-bit slots
  localparam int BONE_DEPTH = (MAX_BONES < 256) ? MAX_BONES : 256;
  localparam int AW = (BONE_DEPTH > 1) ? $clog2(BONE_DEPTH) : 1;

  logic        en;
  logic        wr_en;
  logic [3:0]  wr_col;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0] wr_data;
  logic        beat_valid, beat_oob;
  beat_ctl_t   beat_ctl;
  word_t       beat_pos [3];
  word_t       beat_nrm [3];
  word_t       mat [12];

  logic        xf_valid;
  beat_ctl_t   xf_ctl;
  word_t       xf_pos [3];
  word_t       xf_nrm [3];
  word_t       res_pos [3];
  word_t       res_nrm [3];

  assign en = !out_valid || out_ready;

  lbvs_issue #(
    .MAX_BONES(MAX_BONES),
    .MAX_INFLUENCES(MAX_INFLUENCES),
    .AW(AW)
  ) u_issue (
    .clk, .rst, .en, .in_valid, .in_ready, .mode,
    .pos_x, .pos_y, .pos_z, .nrm_x, .nrm_y, .nrm_z,
    .texcoord, .bone_indices, .weights, .matrix_slot, .last_vertex,
    .wr_en, .wr_col, .wr_addr, .wr_data, .rd_addr,
    .beat_valid, .beat_ctl, .beat_oob, .beat_pos, .beat_nrm
  );

  for (genvar j = 0; j < WORDS_PER_BONE; j++) begin : g_col
    lbvs_ram #(
      .WIDTH(32),
      .DEPTH(BONE_DEPTH)
    ) u_ram (
      .clk,
      .we    (wr_en && (wr_col == 4'(j))),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (en),
      .raddr (rd_addr),
      .rdata (mat[j])
    );
  end

  lbvs_xform u_xform (
    .clk, .rst, .en,
    .in_valid (beat_valid),
    .in_ctl   (beat_ctl),
    .in_oob   (beat_oob),
    .in_pos   (beat_pos),
    .in_nrm   (beat_nrm),
    .mat,
    .out_valid (xf_valid),
    .out_ctl   (xf_ctl),
    .out_pos   (xf_pos),
    .out_nrm   (xf_nrm)
  );

  lbvs_blend u_blend (
    .clk, .rst, .en,
    .in_valid (xf_valid),
    .in_ctl   (xf_ctl),
    .in_pos   (xf_pos),
    .in_nrm   (xf_nrm),
    .out_valid,
    .res_pos,
    .res_nrm,
    .res_tex   (texcoord_out),
    .res_batch (batch_end)
  );

  assign skinned_pos_x = res_pos[0];
  assign skinned_pos_y = res_pos[1];
  assign skinned_pos_z = res_pos[2];
  assign skinned_nrm_x = res_nrm[0];
  assign skinned_nrm_y = res_nrm[1];
  assign skinned_nrm_z = res_nrm[2];

`include "linear_blend_vertex_skinning_top_defines.svh"

  `LBVS_ASSERT_IMP(a_ready_needs_flow, in_ready, !out_valid || out_ready, "in_ready while stalled")
  `LBVS_ASSERT_NEXT(a_stall_holds_issue, out_valid && !out_ready, $stable(beat_valid) && $stable(rd_addr), "issue moved during stall")
  `LBVS_ASSERT_NEXT(a_write_no_beat, in_valid && in_ready && mode == MODE_WRITE && !beat_valid, !beat_valid, "palette write started a beat")

endmodule

>>> hw/rtl/lbvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/lbvs_issue.sv
// Input stage: palette writes and one bone influence issued per cycle while not stalled.
module lbvs_issue #(
  parameter int MAX_BONES = 256,
  parameter int MAX_INFLUENCES = 4,
  parameter int AW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           mode,
  input  lbvs_pkg::word_t      pos_x,
  input  lbvs_pkg::word_t      pos_y,
  input  lbvs_pkg::word_t      pos_z,
  input  lbvs_pkg::word_t      nrm_x,
  input  lbvs_pkg::word_t      nrm_y,
  input  lbvs_pkg::word_t      nrm_z,
  input  logic [63:0]          texcoord,
  input  logic [31:0]          bone_indices,
  input  logic [47:0]          weights,
  input  logic [11:0]          matrix_slot,
  input  logic                 last_vertex,
  output logic                 wr_en,
  output logic [3:0]           wr_col,
  output logic [AW-1:0]        wr_addr,
  output logic [31:0]          wr_data,
  output logic [AW-1:0]        rd_addr,
  output logic                 beat_valid,
  output lbvs_pkg::beat_ctl_t  beat_ctl,
  output logic                 beat_oob,
  output lbvs_pkg::word_t      beat_pos [3],
  output lbvs_pkg::word_t      beat_nrm [3]
);
  import lbvs_pkg::*;

  logic        iss_valid;
  logic [1:0]  k;
  logic [2:0]  md;
  word_t       pos [3];
  word_t       nrm [3];
  logic [31:0] bones;
  logic [47:0] wts;
  logic [63:0] tex;
  logic        batch;

  logic        last_beat, accept, skin;
  logic [7:0]  bone;
  logic signed [WT_W-1:0] rest, wsel, wbeat;
  logic [23:0] slot_prod;
  logic [7:0]  bone_w;
  logic [11:0] base;

  assign last_beat = ({1'b0, k} == md - 3'd1);
  assign in_ready  = en && (!iss_valid || last_beat);
  assign accept    = in_valid && in_ready;
  assign skin      = (mode != MODE_WRITE) && (mode <= 3'd4) &&
                     (32'(mode) <= 32'(MAX_INFLUENCES));

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
      k         <= 2'd0;
    end else if (en) begin
      if (accept && skin) begin
        iss_valid <= 1'b1;
        k         <= 2'd0;
      end else if (iss_valid && !last_beat) begin
        k <= k + 2'd1;
      end else begin
        iss_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && accept && skin) begin
      md     <= mode;
      pos[0] <= pos_x;
      pos[1] <= pos_y;
      pos[2] <= pos_z;
      nrm[0] <= nrm_x;
      nrm[1] <= nrm_y;
      nrm[2] <= nrm_z;
      bones  <= bone_indices;
      wts    <= weights;
      tex    <= texcoord;
      batch  <= last_vertex;
    end
  end

  // implied weight of the last influence; mode 2 turns the lerp into two weights
  always_comb begin
    rest = ONE_Q15;
    if (md >= 3'd2) rest = rest - {3'b000, wts[15:0]};
    if (md >= 3'd3) rest = rest - {3'b000, wts[31:16]};
    if (md >= 3'd4) rest = rest - {3'b000, wts[47:32]};
    unique case (k)
      2'd0: begin
        wsel = {3'b000, wts[15:0]};
        bone = bones[7:0];
      end
      2'd1: begin
        wsel = {3'b000, wts[31:16]};
        bone = bones[15:8];
      end
      2'd2: begin
        wsel = {3'b000, wts[47:32]};
        bone = bones[23:16];
      end
      default: begin
        wsel = '0;
        bone = bones[31:24];
      end
    endcase
    // lerp: bone 0 takes one minus weight 0, bone 1 takes weight 0
    if (md == 3'd2) begin
      wbeat = last_beat ? {3'b000, wts[15:0]} : rest;
    end else begin
      wbeat = last_beat ? rest : wsel;
    end
  end

  assign rd_addr    = bone[AW-1:0];
  assign beat_valid = iss_valid;
  assign beat_oob   = 32'(bone) >= 32'(MAX_BONES);
  assign beat_ctl   = '{first: (k == 2'd0), last: last_beat,
                        wt: wbeat, texcoord: tex, batch: batch};
  assign beat_pos   = pos;
  assign beat_nrm   = nrm;

  // slot / 12 by reciprocal, column as remainder
  assign slot_prod = 24'(matrix_slot) * 24'(RECIP_12);
  assign bone_w    = slot_prod[22:15];
  assign base      = 12'({4'b0000, bone_w} * 12'(WORDS_PER_BONE));
  assign wr_col    = 4'(matrix_slot - base);
  assign wr_addr   = bone_w[AW-1:0];
  assign wr_data   = pos_x;
  assign wr_en     = accept && (mode == MODE_WRITE) &&
                     (32'(matrix_slot) < 32'(MAX_BONES) * 32'(WORDS_PER_BONE));

endmodule

>>> hw/rtl/lbvs_xform.sv
// Per-bone transform: products, then row sums with translation and saturation.
module lbvs_xform (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  lbvs_pkg::beat_ctl_t  in_ctl,
  input  logic                 in_oob,
  input  lbvs_pkg::word_t      in_pos [3],
  input  lbvs_pkg::word_t      in_nrm [3],
  input  lbvs_pkg::word_t      mat [12],
  output logic                 out_valid,
  output lbvs_pkg::beat_ctl_t  out_ctl,
  output lbvs_pkg::word_t      out_pos [3],
  output lbvs_pkg::word_t      out_nrm [3]
);
  import lbvs_pkg::*;

  // stage 1 lines up with the registered palette read
  logic      s1_valid, s1_oob;
  beat_ctl_t s1_ctl;
  word_t     s1_pos [3];
  word_t     s1_nrm [3];

  logic      s2_valid;
  beat_ctl_t s2_ctl;
  logic signed [47:0] s2_rp [3][3];
  logic signed [47:0] s2_rn [3][3];
  word_t     s2_tr [3];

  word_t m [12];
  logic signed [63:0] pp [3][3];
  logic signed [63:0] pn [3][3];
  logic signed [49:0] sp [3];
  logic signed [49:0] sn [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      m[i] = s1_oob ? '0 : mat[i];
    end
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        pp[c][r] = 64'(s1_pos[r]) * 64'(m[r*3+c]);
        pn[c][r] = 64'(s1_nrm[r]) * 64'(m[r*3+c]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      sp[c] = 50'(s2_tr[c]) + 50'(s2_rp[c][0]) + 50'(s2_rp[c][1]) + 50'(s2_rp[c][2]);
      sn[c] = 50'(s2_rn[c][0]) + 50'(s2_rn[c][1]) + 50'(s2_rn[c][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctl <= in_ctl;
      s1_oob <= in_oob;
      s1_pos <= in_pos;
      s1_nrm <= in_nrm;
      s2_ctl <= s1_ctl;
      out_ctl <= s2_ctl;
      for (int c = 0; c < 3; c++) begin
        s2_tr[c] <= m[9+c];
        for (int r = 0; r < 3; r++) begin
          // round half up to Q16.16
          s2_rp[c][r] <= 48'((pp[c][r] + 64'sd32768) >>> 16);
          s2_rn[c][r] <= 48'((pn[c][r] + 64'sd32768) >>> 16);
        end
        out_pos[c] <= sat32(64'(sp[c]));
        out_nrm[c] <= sat32(64'(sn[c]));
      end
    end
  end

endmodule

>>> hw/rtl/lbvs_blend.sv
// Weighting, accumulation over influences, rounding and the output register.
module lbvs_blend (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  lbvs_pkg::beat_ctl_t  in_ctl,
  input  lbvs_pkg::word_t      in_pos [3],
  input  lbvs_pkg::word_t      in_nrm [3],
  output logic                 out_valid,
  output lbvs_pkg::word_t      res_pos [3],
  output lbvs_pkg::word_t      res_nrm [3],
  output logic [63:0]          res_tex,
  output logic                 res_batch
);
  import lbvs_pkg::*;

  logic      b1_valid;
  beat_ctl_t b1_ctl;
  logic signed [50:0] b1_wp [3];
  logic signed [50:0] b1_wn [3];

  logic signed [52:0] acc_p [3];
  logic signed [52:0] acc_n [3];
  logic signed [52:0] sum_p [3];
  logic signed [52:0] sum_n [3];

  logic        fin_valid;
  logic signed [52:0] fin_p [3];
  logic signed [52:0] fin_n [3];
  logic [63:0] fin_tex;
  logic        fin_batch;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_p[c] = (b1_ctl.first ? 53'sd0 : acc_p[c]) + 53'(b1_wp[c]);
      sum_n[c] = (b1_ctl.first ? 53'sd0 : acc_n[c]) + 53'(b1_wn[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= in_valid;
      fin_valid <= b1_valid && b1_ctl.last;
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_ctl <= in_ctl;
      for (int c = 0; c < 3; c++) begin
        b1_wp[c] <= 51'(in_pos[c]) * 51'(in_ctl.wt);
        b1_wn[c] <= 51'(in_nrm[c]) * 51'(in_ctl.wt);
      end
      if (b1_valid) begin
        acc_p <= sum_p;
        acc_n <= sum_n;
      end
      fin_p     <= sum_p;
      fin_n     <= sum_n;
      fin_tex   <= b1_ctl.texcoord;
      fin_batch <= b1_ctl.batch;
      if (fin_valid) begin
        for (int c = 0; c < 3; c++) begin
          res_pos[c] <= sat32(64'((fin_p[c] + 53'sd16384) >>> 15));
          res_nrm[c] <= sat32(64'((fin_n[c] + 53'sd16384) >>> 15));
        end
        res_tex   <= fin_tex;
        res_batch <= fin_batch;
      end
    end
  end

endmodule
